>>> rtl/bdq_pkg.sv
// Package for the bounded deque with ordered insert.
// Command codes, status codes, cell modes, control struct and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;

	typedef enum logic [OP_W-1:0] {
		OP_SHOW       = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_INSERT     = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 2'd0,
		STS_EMPTY      = 2'd1,
		STS_FULL       = 2'd2,
		STS_NOT_PLACED = 2'd3
	} status_t;

	// what every cell does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS_FRONT,
		CELL_INS_BACK,
		CELL_INS_ORD,
		CELL_SHL,
		CELL_DROP,
		CELL_ROT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t        mode;
		logic [DATA_W-1:0] value;  // value being inserted
		logic [DATA_W-1:0] head;   // front entry, wraps to the tail on rotate
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHOW
	} state_t;

endpackage

>>> rtl/bdq_cell.sv
// One slot of the deque chain: holds an entry and its valid flag.
// Exchanges entries with both neighbors; uses bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bdq_pkg::cell_ctl_t         ctl,
	input  logic [bdq_pkg::DATA_W-1:0] left_entry,
	input  logic                       left_valid,
	input  logic                       left_lt,
	input  logic                       left_pin,
	input  logic [bdq_pkg::DATA_W-1:0] right_entry,
	input  logic                       right_valid,
	output logic [bdq_pkg::DATA_W-1:0] entry,
	output logic                       valid,
	output logic                       lt,
	output logic                       pin
);

	logic [bdq_pkg::DATA_W-1:0] entry_q;
	logic                       valid_q;
	logic                       take;
	logic                       ins;

	// entry strictly below the value being inserted
	assign lt = valid_q && ($signed(entry_q) < $signed(ctl.value));

	always_comb begin
		unique case (ctl.mode)
			bdq_pkg::CELL_INS_FRONT: take = 1'b1;
			bdq_pkg::CELL_INS_BACK:  take = left_valid && !valid_q;
			// gap between left neighbor and this one, or the tail end
			bdq_pkg::CELL_INS_ORD:   take = left_valid && left_lt &&
				(!valid_q || ($signed(ctl.value) < $signed(entry_q)));
			default:                 take = 1'b0;
		endcase
	end

	assign ins = (ctl.mode == bdq_pkg::CELL_INS_FRONT) ||
		(ctl.mode == bdq_pkg::CELL_INS_BACK) || (ctl.mode == bdq_pkg::CELL_INS_ORD);

	// set once the insert point lies at or before this cell
	assign pin = left_pin || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.mode)
				bdq_pkg::CELL_SHL,
				bdq_pkg::CELL_DROP: valid_q <= right_valid;
				default: begin
					if (ins && left_pin)
						valid_q <= left_valid;
					else if (ins && take)
						valid_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			bdq_pkg::CELL_SHL: entry_q <= right_entry;
			bdq_pkg::CELL_ROT: begin
				if (right_valid)
					entry_q <= right_entry;
				else if (valid_q)
					entry_q <= ctl.head;
			end
			default: begin
				if (ins && left_pin)
					entry_q <= left_entry;
				else if (ins && take)
					entry_q <= ctl.value;
			end
		endcase
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

>>> rtl/bounded_deque_with_ordered_insert_core.sv
// Top level of the bounded deque with ordered insert.
// Chain of bdq_cell slots plus command FSM; uses bdq_pkg.
`timescale 1ns / 1ps

// Each command is taken when start is high and busy is low, and its result
// appears in the next cycle on the result ports with done high for one cycle;
// results cannot be held off. For push, pop and ordered insert every cell
// compares and shifts at once, and the insert point ripples down the chain
// as a one-bit flag. Show reads out every entry held (a single result on an
// empty list): the chain rotates by one slot per cycle and the front slot is
// read out, with busy high until the last entry is read out.

module bounded_deque_with_ordered_insert_core #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bdq_pkg::OP_W-1:0]     op,
	input  logic [bdq_pkg::DATA_W-1:0]   value,
	output logic                         done,
	output logic [bdq_pkg::DATA_W-1:0]   out_value,
	output logic [bdq_pkg::STATUS_W-1:0] status,
	output logic [bdq_pkg::COUNT_W-1:0]  entry_count,
	output logic                         last
);

	localparam int CW = $clog2(DEPTH + 1);

	bdq_pkg::state_t    state_q, state_d;
	bdq_pkg::cell_ctl_t ctl;
	logic [CW-1:0]      cnt_q, cnt_d, rem_q;
	logic               accept;
	logic               full, empty, placed;

	logic [bdq_pkg::DATA_W-1:0] e_w   [DEPTH];
	logic [DEPTH-1:0]           vld_w;
	logic [DEPTH-1:0]           lt_w;
	logic [DEPTH-1:0]           pin_w;

	logic                         res_vld;
	logic [bdq_pkg::DATA_W-1:0]   res_val;
	bdq_pkg::status_t             res_st;
	logic                         res_last;

	logic                         done_q;
	logic [bdq_pkg::DATA_W-1:0]   out_value_q;
	logic [bdq_pkg::STATUS_W-1:0] status_q;
	logic [bdq_pkg::COUNT_W-1:0]  entry_count_q;
	logic                         last_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [bdq_pkg::DATA_W-1:0] l_e, r_e;
			logic                       l_v, l_lt, l_pin, r_v;
			if (gi == 0) begin : g_first
				assign l_e   = '0;
				assign l_v   = 1'b1;
				assign l_lt  = 1'b1;
				assign l_pin = 1'b0;
			end else begin : g_mid
				assign l_e   = e_w[gi-1];
				assign l_v   = vld_w[gi-1];
				assign l_lt  = lt_w[gi-1];
				assign l_pin = pin_w[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign r_e = '0;
				assign r_v = 1'b0;
			end else begin : g_inner
				assign r_e = e_w[gi+1];
				assign r_v = vld_w[gi+1];
			end
			bdq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.left_entry  (l_e),
				.left_valid  (l_v),
				.left_lt     (l_lt),
				.left_pin    (l_pin),
				.right_entry (r_e),
				.right_valid (r_v),
				.entry       (e_w[gi]),
				.valid       (vld_w[gi]),
				.lt          (lt_w[gi]),
				.pin         (pin_w[gi])
			);
		end
	endgenerate

	assign busy   = (state_q == bdq_pkg::ST_SHOW);
	assign accept = start && !busy;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign placed = pin_w[DEPTH-1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (accept && (op == bdq_pkg::OP_SHOW) && (cnt_q > CW'(1)))
					state_d = bdq_pkg::ST_SHOW;
			end
			bdq_pkg::ST_SHOW: begin
				if (rem_q == CW'(1))
					state_d = bdq_pkg::ST_IDLE;
			end
			default: state_d = bdq_pkg::ST_IDLE;
		endcase
	end

	// cell control
	always_comb begin
		ctl.mode  = bdq_pkg::CELL_HOLD;
		ctl.value = value;
		ctl.head  = e_w[0];
		unique case (state_q)
			bdq_pkg::ST_SHOW: ctl.mode = bdq_pkg::CELL_ROT;
			default: begin
				if (accept) begin
					unique case (bdq_pkg::op_t'(op))
						bdq_pkg::OP_SHOW: begin
							if (!empty)
								ctl.mode = bdq_pkg::CELL_ROT;
						end
						bdq_pkg::OP_PUSH_FRONT: begin
							if (!full)
								ctl.mode = bdq_pkg::CELL_INS_FRONT;
						end
						bdq_pkg::OP_PUSH_BACK: begin
							if (!full)
								ctl.mode = bdq_pkg::CELL_INS_BACK;
						end
						bdq_pkg::OP_POP_FRONT: begin
							if (!empty)
								ctl.mode = bdq_pkg::CELL_SHL;
						end
						bdq_pkg::OP_POP_BACK: begin
							if (!empty)
								ctl.mode = bdq_pkg::CELL_DROP;
						end
						bdq_pkg::OP_INSERT: begin
							if (!full)
								ctl.mode = bdq_pkg::CELL_INS_ORD;
						end
						default: ;  // unused codes leave the list alone
					endcase
				end
			end
		endcase
	end

	// result and next count
	always_comb begin
		res_vld   = 1'b0;
		res_val   = '0;
		res_st    = bdq_pkg::STS_OK;
		res_last  = 1'b1;
		cnt_d     = cnt_q;
		unique case (state_q)
			bdq_pkg::ST_SHOW: begin
				res_vld  = 1'b1;
				res_val  = e_w[0];
				res_last = (rem_q == CW'(1));
			end
			default: begin
				if (accept) begin
					res_vld = 1'b1;
					unique case (bdq_pkg::op_t'(op))
						bdq_pkg::OP_SHOW: begin
							if (empty) begin
								res_st = bdq_pkg::STS_EMPTY;
							end else begin
								res_val  = e_w[0];
								res_last = (cnt_q == CW'(1));
							end
						end
						bdq_pkg::OP_PUSH_FRONT,
						bdq_pkg::OP_PUSH_BACK: begin
							if (full)
								res_st = bdq_pkg::STS_FULL;
							else
								cnt_d = cnt_q + CW'(1);
						end
						bdq_pkg::OP_POP_FRONT,
						bdq_pkg::OP_POP_BACK: begin
							if (empty)
								res_st = bdq_pkg::STS_EMPTY;
							else
								cnt_d = cnt_q - CW'(1);
						end
						bdq_pkg::OP_INSERT: begin
							if (full)
								res_st = bdq_pkg::STS_FULL;
							else if (placed)
								cnt_d = cnt_q + CW'(1);
							else
								res_st = bdq_pkg::STS_NOT_PLACED;
						end
						default: ;  // unused codes leave the list alone
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= res_vld;
			if (state_q == bdq_pkg::ST_SHOW)
				rem_q <= rem_q - CW'(1);
			else if (accept)
				rem_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		out_value_q   <= res_val;
		status_q      <= res_st;
		entry_count_q <= bdq_pkg::COUNT_W'(cnt_d);
		last_q        <= res_last;
	end

	assign done        = done_q;
	assign out_value   = out_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

	// as many valid flags as the count, the front one set unless the list is empty
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_w) == int'(cnt_q) && (vld_w[0] || cnt_q == '0))
		else $error("valid flags disagree with entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_show_stream: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bdq_pkg::ST_SHOW |=> done)
		else $error("show readout skipped a cycle");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op != bdq_pkg::OP_SHOW |=> done && last && out_value == '0)
		else $error("non-show transaction gave wrong result framing");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(cnt_q))
		else $error("entry count changed without a transaction");

endmodule
